// File: rtl/tfwr_pkg.sv
// ----------------------------------------------------------------------------
// tfwr_pkg
// Shared types and constants of the TFTP write block receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfwr_pkg;

   // event kinds
   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_PACKET  = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT = 2'd2;

   // session phases, also reported as session_status
   localparam logic [2:0] PHASE_IDLE  = 3'd0;
   localparam logic [2:0] PHASE_RECV  = 3'd1;
   localparam logic [2:0] PHASE_FINAL = 3'd2;
   localparam logic [2:0] PHASE_DONE  = 3'd3;
   localparam logic [2:0] PHASE_FAIL  = 3'd4;

   localparam logic [15:0] OP_DATA   = 16'd3;
   localparam logic [15:0] HDR_BYTES = 16'd4;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_LIMIT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_BLOCK_BYTES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_WAIT_LIMIT = 2'd2;

   localparam logic [7:0]  RETRY_LIMIT_RST      = 8'd5;
   localparam logic [12:0] FULL_BLOCK_BYTES_RST = 13'd512;
   localparam logic [3:0]  FINAL_WAIT_LIMIT_RST = 4'd3;

   typedef struct packed {
      logic [7:0]  retry_limit;
      logic [12:0] full_block_bytes;
      logic [3:0]  final_wait_limit;
   } cfg_type;

   // classified event, as queued between front and back
   typedef struct packed {
      logic [1:0]  mode;
      logic        is_data;
      logic [15:0] block;
      logic [15:0] payload_length;
   } evt_type;

endpackage

// File: rtl/tfwr_if.sv
// ----------------------------------------------------------------------------
// tfwr_if
// Valid/ready channels for event beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tfwr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        source_matches;
   logic [15:0] packet_opcode;
   logic [15:0] packet_block;
   logic [15:0] packet_length;

   modport source (output valid, mode, source_matches, packet_opcode, packet_block,
                   packet_length, input ready);
   modport sink (input valid, mode, source_matches, packet_opcode, packet_block,
                 packet_length, output ready);
endinterface

interface tfwr_rsp_if;
   logic        valid;
   logic        ready;
   logic        accept_payload;
   logic [15:0] payload_length;
   logic        send_ack;
   logic [15:0] ack_block;
   logic        ack_is_repeat;
   logic [2:0]  session_status;

   modport source (output valid, accept_payload, payload_length, send_ack, ack_block,
                   ack_is_repeat, session_status, input ready);
   modport sink (input valid, accept_payload, payload_length, send_ack, ack_block,
                 ack_is_repeat, session_status, output ready);
endinterface

// File: rtl/tftp_write_block_receiver_top.sv
// ----------------------------------------------------------------------------
// tftp_write_block_receiver_top
// Receiving side of a TFTP write session, lock-step block sequencer.
//
// req_chan carries one event beat: start, packet header or receive timeout.
// rsp_chan returns exactly one result beat per event, in order: payload
// accept and length, ACK request with its block number and repeat flag, and
// the session status after the event.
// The csr_ port writes retry_limit, full_block_bytes and final_wait_limit;
// write it only while no event is in flight.
// An accepted beat passes through the queue and then the result register to rsp_chan.
// Throughput: one event per cycle while rsp_chan is not stalled, set by the
// session update in the back end; a queue of QUEUE_DEPTH beats sits in front of it.
// When rsp_chan stalls, the result register holds, the queue fills and
// req_chan.ready drops once QUEUE_DEPTH beats are waiting.
// Reset (synchronous) empties the queue and result register, returns the
// session to idle and the registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tftp_write_block_receiver_top
   import tfwr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   tfwr_req_if.sink                req_chan,
   tfwr_rsp_if.source              rsp_chan,
   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   evt_type evt;
   logic    evt_valid;
   logic    evt_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RETRY_LIMIT:      cfg_in.retry_limit      = csr_wdata[7:0];
            CSR_FULL_BLOCK_BYTES: cfg_in.full_block_bytes = csr_wdata[12:0];
            CSR_FINAL_WAIT_LIMIT: cfg_in.final_wait_limit = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit      <= RETRY_LIMIT_RST;
         cfg_ff.full_block_bytes <= FULL_BLOCK_BYTES_RST;
         cfg_ff.final_wait_limit <= FINAL_WAIT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tfwr_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .evt       (evt),
      .evt_valid (evt_valid),
      .evt_pop   (evt_pop)
   );

   tfwr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .evt       (evt),
      .evt_valid (evt_valid),
      .evt_pop   (evt_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: rtl/tfwr_front.sv
// ----------------------------------------------------------------------------
// tfwr_front
// Takes event beats, classifies packets and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfwr_front
   import tfwr_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic            clock,
   input  logic            reset,
   tfwr_req_if.sink        req_chan,
   output evt_type         evt,
   output logic            evt_valid,
   input  logic            evt_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   evt_type            q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   evt_type            cls;
   logic               push;
   logic               pop;

   // a beat is DATA only from the client, with a full header and the DATA opcode
   always_comb begin
      cls.mode           = req_chan.mode;
      cls.is_data        = req_chan.source_matches && (req_chan.packet_length >= HDR_BYTES)
                           && (req_chan.packet_opcode == OP_DATA);
      cls.block          = req_chan.packet_block;
      cls.payload_length = req_chan.packet_length - HDR_BYTES;
   end

   assign req_chan.ready = (count_ff != CNT_FULL);
   assign push           = req_chan.valid && req_chan.ready;
   assign evt_valid      = (count_ff != '0);
   assign pop            = evt_pop && evt_valid;
   assign evt            = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

endmodule

// File: rtl/tfwr_back.sv
// ----------------------------------------------------------------------------
// tfwr_back
// Session sequencer: runs one queued event per cycle into the result register when it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfwr_back
   import tfwr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  evt_type         evt,
   input  logic            evt_valid,
   output logic            evt_pop,
   tfwr_rsp_if.source      rsp_chan
);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] expected_ff, expected_in;
   logic [15:0] last_ack_ff, last_ack_in;
   logic [7:0]  timeout_cnt_ff, timeout_cnt_in;
   logic [3:0]  fwait_cnt_ff, fwait_cnt_in;

   logic        rsp_valid_ff;
   logic        accept_ff, accept_in;
   logic [15:0] plen_ff, plen_in;
   logic        ack_ff, ack_in;
   logic [15:0] ack_block_ff, ack_block_in;
   logic        repeat_ff, repeat_in;

   logic [8:0]  timeout_next;
   logic [3:0]  fwait_next;

   // result register frees up whenever it is empty or being taken this cycle
   assign evt_pop = evt_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign timeout_next = {1'b0, timeout_cnt_ff} + 9'd1;
   assign fwait_next   = fwait_cnt_ff + 4'd1;

   always_comb begin
      phase_in       = phase_ff;
      expected_in    = expected_ff;
      last_ack_in    = last_ack_ff;
      timeout_cnt_in = timeout_cnt_ff;
      fwait_cnt_in   = fwait_cnt_ff;
      accept_in      = 1'b0;
      plen_in        = '0;
      ack_in         = 1'b0;
      ack_block_in   = '0;
      repeat_in      = 1'b0;
      if (evt.mode == MODE_START) begin
         phase_in       = PHASE_RECV;
         expected_in    = 16'd1;
         last_ack_in    = '0;
         timeout_cnt_in = '0;
         fwait_cnt_in   = '0;
         ack_in         = 1'b1;
      end else begin
         unique case (phase_ff)
            PHASE_RECV: begin
               if (evt.mode == MODE_PACKET && evt.is_data) begin
                  if (evt.block == expected_ff) begin
                     accept_in      = 1'b1;
                     plen_in        = evt.payload_length;
                     ack_in         = 1'b1;
                     ack_block_in   = evt.block;
                     last_ack_in    = evt.block;
                     timeout_cnt_in = '0;
                     expected_in    = expected_ff + 16'd1;
                     if (evt.payload_length < {3'b000, cfg.full_block_bytes}) begin
                        phase_in     = PHASE_FINAL;
                        fwait_cnt_in = '0;
                     end
                  end else if (evt.block == expected_ff - 16'd1) begin
                     ack_in       = 1'b1;
                     ack_block_in = evt.block;
                     repeat_in    = 1'b1;
                     last_ack_in  = evt.block;
                  end
               end else if (evt.mode == MODE_TIMEOUT) begin
                  if (timeout_next > {1'b0, cfg.retry_limit}) begin
                     phase_in = PHASE_FAIL;
                  end else begin
                     timeout_cnt_in = timeout_next[7:0];
                     ack_in         = 1'b1;
                     ack_block_in   = last_ack_ff;
                     repeat_in      = 1'b1;
                  end
               end
            end
            PHASE_FINAL: begin
               if (evt.mode == MODE_TIMEOUT) begin
                  phase_in = PHASE_DONE;
               end else if (evt.mode == MODE_PACKET) begin
                  // every packet counts, whatever its source or header
                  if (evt.is_data && evt.block == last_ack_ff) begin
                     ack_in       = 1'b1;
                     ack_block_in = last_ack_ff;
                     repeat_in    = 1'b1;
                  end
                  fwait_cnt_in = fwait_next;
                  if (fwait_next >= cfg.final_wait_limit) begin
                     phase_in = PHASE_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_IDLE;
         expected_ff    <= 16'd1;
         last_ack_ff    <= '0;
         timeout_cnt_ff <= '0;
         fwait_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (evt_pop) begin
            phase_ff       <= phase_in;
            expected_ff    <= expected_in;
            last_ack_ff    <= last_ack_in;
            timeout_cnt_ff <= timeout_cnt_in;
            fwait_cnt_ff   <= fwait_cnt_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (evt_pop) begin
         accept_ff    <= accept_in;
         plen_ff      <= plen_in;
         ack_ff       <= ack_in;
         ack_block_ff <= ack_block_in;
         repeat_ff    <= repeat_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accept_payload = accept_ff;
   assign rsp_chan.payload_length = plen_ff;
   assign rsp_chan.send_ack       = ack_ff;
   assign rsp_chan.ack_block      = ack_block_ff;
   assign rsp_chan.ack_is_repeat  = repeat_ff;
   assign rsp_chan.session_status = phase_ff;

   a_accept_acks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && accept_ff |-> ack_ff && !repeat_ff && phase_ff != PHASE_IDLE)
      else $error("accepted block without a fresh ACK");

   a_start_recv: assert property (@(posedge clock) disable iff (reset)
      evt_pop && evt.mode == MODE_START |=> phase_ff == PHASE_RECV && last_ack_ff == '0)
      else $error("start did not open a session");

   a_final_timeout: assert property (@(posedge clock) disable iff (reset)
      evt_pop && evt.mode == MODE_TIMEOUT && phase_ff == PHASE_FINAL
      |=> phase_ff == PHASE_DONE && !ack_ff)
      else $error("timeout in final wait did not complete");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> $stable(phase_ff) && $stable(expected_ff))
      else $error("state moved while result was stalled");

endmodule
